[hw/rtl/bitmap_page_frame_allocator_core_defines.svh]
// assertion macros for the bitmap page frame allocator
// no dependencies; included by the top level
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BPFA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define BPFA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define BPFA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define BPFA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/bpfa_pkg.sv]
// shared types, codes and constants of the bitmap page frame allocator
// no dependencies; imported by every module of the block
package bpfa_pkg;

    localparam int DEF_MAX_PAGES = 65536;
    localparam int DEF_WORD_BITS = 64;
    localparam int CFG_W         = 17;
    localparam int COUNT_W       = 17;
    localparam int PAGE_W        = 16;
    localparam int BLOCK_W       = 7;
    localparam int SCAN_POS_W    = 6;

    localparam logic [BLOCK_W-1:0] MAX_BLOCKS     = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 17'h1FFFF;
    localparam logic [CFG_W-1:0]   PAGE_COUNT_RST = 17'd65536;

    typedef enum logic [1:0] {
        ACT_ALLOC     = 2'd0,
        ACT_FREE      = 2'd1,
        ACT_LOCK      = 2'd2,
        ACT_UNRESERVE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2,
        ST_ALREADY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR  = 2'd0,
        S_IDLE   = 2'd1,
        S_ALLOC  = 2'd2,
        S_MODIFY = 2'd3
    } state_t;

    // result of the first-clear search
    typedef struct packed {
        logic                  found;
        logic [SCAN_POS_W-1:0] pos;
    } bpfa_hit_t;

    function automatic logic [COUNT_W-1:0] cnt_inc(input logic [COUNT_W-1:0] v,
                                                    input logic [COUNT_W-1:0] top);
        logic [COUNT_W-1:0] r;
        r = (v >= top) ? top : COUNT_W'(v + 1'b1);
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] cnt_dec(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = (v == '0) ? '0 : COUNT_W'(v - 1'b1);
        return r;
    endfunction

endpackage

[hw/rtl/bitmap_page_frame_allocator_core.sv]
// top level of the bitmap page frame allocator: sequencer, counters, hint
// depends on bpfa_pkg, bpfa_zero_scan, bpfa_map_ram and the defines header
//
//  channel   handshake             payload
//  command   start / busy          action, page, block_count
//  result    done (1-cycle strobe) first_page, status, free/used/reserved_pages
//  config    cfg_valid / cfg_ready cfg_data (page_count)
//
// a command is taken when start is high and busy low; free, lock and unreserve
// do one memory read, then modify and write back of one word
// allocate searches from the hint until the block count is met or the search fails
// after reset and after every page_count write a clearing pass over all MAP_WORDS
// words (1024 by default) zeroes the bitmap with busy high
// the done strobe is high for exactly one cycle; the receiver cannot stall it
`include "bitmap_page_frame_allocator_core_defines.svh"

module bitmap_page_frame_allocator_core import bpfa_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES,
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    // command
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [PAGE_W-1:0]  page,
    input  logic [BLOCK_W-1:0] block_count,
    // result
    output logic               done,
    output logic [PAGE_W-1:0]  first_page,
    output logic [1:0]         status,
    output logic [COUNT_W-1:0] free_pages,
    output logic [COUNT_W-1:0] used_pages,
    output logic [COUNT_W-1:0] reserved_pages,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data
);

    // memory words are rounded up to a power of two bits
    localparam int SHIFT      = $clog2(WORD_BITS);
    localparam int SLICE_BITS = 1 << SHIFT;
    localparam int MAP_WORDS  = (MAX_PAGES + SLICE_BITS - 1) / SLICE_BITS;
    localparam int ADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W      = CFG_W;

    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);
    localparam logic [IDX_W-1:0]  LOW_ONES  = IDX_W'(SLICE_BITS - 1);
    // largest usable page count
    localparam logic [IDX_W-1:0]  PAGE_CAP  =
        (MAX_PAGES > 131071) ? 17'h1FFFF : IDX_W'(MAX_PAGES);
    localparam logic [IDX_W-1:0]  LIM_RST   =
        (PAGE_COUNT_RST > PAGE_CAP) ? PAGE_CAP : PAGE_COUNT_RST;

    // sequencer state
    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;

    // allocator state
    logic [IDX_W-1:0]      lim_reg, lim_next;
    logic [IDX_W-1:0]      hint_reg, hint_next;
    logic [COUNT_W-1:0]    free_reg, free_next;
    logic [COUNT_W-1:0]    used_reg, used_next;
    logic [COUNT_W-1:0]    resv_reg, resv_next;

    // per-command working registers
    action_t               action_reg, action_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    logic [BLOCK_W-1:0]    remain_reg, remain_next;
    logic [PAGE_W-1:0]     first_reg, first_next;
    logic                  got_reg, got_next;
    logic                  dirty_reg, dirty_next;
    logic                  from_ram_reg, from_ram_next;
    logic [SLICE_BITS-1:0] word_reg, word_next;

    // result registers
    logic                  done_reg, done_next;
    logic [PAGE_W-1:0]     first_page_reg, first_page_next;
    status_t               status_reg, status_next;

    // memory port
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [SLICE_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [SLICE_BITS-1:0] ram_rdata;

    // scan datapath
    bpfa_hit_t             hit;
    logic [SLICE_BITS-1:0] word_cur;
    logic [SLICE_BITS-1:0] word_set;
    logic [IDX_W-1:0]      hint_word;
    logic [ADDR_W-1:0]     hint_addr;
    logic [IDX_W-1:0]      cand;
    logic [IDX_W:0]        next_base;
    logic                  hint_live;
    logic                  take_ok;
    logic                  next_ok;
    logic                  alloc_fail;
    logic                  alloc_last;
    logic                  alloc_end;

    // modify datapath
    logic [ADDR_W-1:0]     page_addr_in;
    logic [ADDR_W-1:0]     page_addr;
    logic                  page_bit;
    logic                  page_ok;
    logic [SHIFT-1:0]      page_off;
    logic [BLOCK_W-1:0]    eff_blocks;
    logic [IDX_W-1:0]      cfg_lim;

    bpfa_map_ram #(
        .DEPTH  (MAP_WORDS),
        .DATA_W (SLICE_BITS),
        .ADDR_W (ADDR_W)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bpfa_zero_scan #(
        .SLICE_BITS (SLICE_BITS)
    ) u_zero_scan (
        .word   (word_cur),
        .offset (hint_reg[SHIFT-1:0]),
        .hit    (hit)
    );

    // first scan cycle of a word works on fresh memory data, later ones on the copy
    assign word_cur  = from_ram_reg ? ram_rdata : word_reg;
    assign hint_word = hint_reg >> SHIFT;
    assign hint_addr = ADDR_W'(hint_word);
    assign cand      = {hint_reg[IDX_W-1:SHIFT], hit.pos[SHIFT-1:0]};
    assign next_base = {1'b0, hint_reg | LOW_ONES} + 1'b1;
    assign hint_live = hint_reg < lim_reg;
    assign take_ok   = hint_live && hit.found && (cand < lim_reg);
    assign next_ok   = next_base < {1'b0, lim_reg};

    // a clear bit past the page limit, or no next word, ends the search
    assign alloc_fail = !take_ok && (!hint_live || hit.found || !next_ok);
    assign alloc_last = take_ok && (remain_reg == BLOCK_W'(1));
    assign alloc_end  = alloc_fail || alloc_last;

    always_comb
    begin
        word_set = word_cur;
        word_set[hit.pos[SHIFT-1:0]] = 1'b1;
    end

    assign page_addr_in = ADDR_W'(IDX_W'(page) >> SHIFT);
    assign page_addr    = ADDR_W'(IDX_W'(page_reg) >> SHIFT);
    assign page_off     = page_reg[SHIFT-1:0];
    assign page_bit     = ram_rdata[page_off];
    assign page_ok      = {1'b0, page_reg} < lim_reg;

    // zero acts as one, large requests are cut
    assign eff_blocks = (block_count == '0)        ? BLOCK_W'(1) :
                        (block_count > MAX_BLOCKS) ? MAX_BLOCKS  : block_count;
    assign cfg_lim    = (cfg_data > PAGE_CAP) ? PAGE_CAP : cfg_data;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (action_t'(action) == ACT_ALLOC) ? S_ALLOC : S_MODIFY;
                end
            end
            S_ALLOC:
            begin
                if (alloc_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MODIFY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        // a page_count write restarts the block
        if (cfg_valid)
        begin
            state_next = S_CLEAR;
        end
    end

    // datapath and memory control
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        lim_next        = lim_reg;
        hint_next       = hint_reg;
        free_next       = free_reg;
        used_next       = used_reg;
        resv_next       = resv_reg;
        action_next     = action_reg;
        page_next       = page_reg;
        remain_next     = remain_reg;
        first_next      = first_reg;
        got_next        = got_reg;
        dirty_next      = dirty_reg;
        from_ram_next   = from_ram_reg;
        word_next       = word_reg;
        done_next       = 1'b0;
        first_page_next = first_page_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = hint_addr;
        ram_wdata       = word_cur;
        ram_raddr       = hint_addr;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = ADDR_W'(clr_addr_reg + 1'b1);
            end
            S_IDLE:
            begin
                // read ahead so the word is there in the next cycle
                if (action_t'(action) != ACT_ALLOC)
                begin
                    ram_raddr = page_addr_in;
                end
                if (start)
                begin
                    action_next   = action_t'(action);
                    page_next     = page;
                    remain_next   = eff_blocks;
                    got_next      = 1'b0;
                    dirty_next    = 1'b0;
                    from_ram_next = 1'b1;
                end
            end
            S_ALLOC:
            begin
                if (take_ok)
                begin
                    free_next   = cnt_dec(free_reg);
                    used_next   = cnt_inc(used_reg, COUNT_MAX);
                    resv_next   = cnt_inc(resv_reg, COUNT_MAX);
                    hint_next   = cand;
                    remain_next = BLOCK_W'(remain_reg - 1'b1);
                    got_next    = 1'b1;
                    if (!got_reg)
                    begin
                        first_next = cand[PAGE_W-1:0];
                    end
                    if (alloc_last)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = word_set;
                        done_next       = 1'b1;
                        status_next     = ST_DONE;
                        first_page_next = got_reg ? first_reg : cand[PAGE_W-1:0];
                    end
                    else
                    begin
                        word_next     = word_set;
                        dirty_next    = 1'b1;
                        from_ram_next = 1'b0;
                    end
                end
                else
                begin
                    // leaving this word: put back any bits taken in it
                    ram_we = dirty_reg;
                    if (alloc_fail)
                    begin
                        hint_next       = lim_reg;
                        done_next       = 1'b1;
                        status_next     = ST_NO_FREE;
                        first_page_next = got_reg ? first_reg : '0;
                    end
                    else
                    begin
                        hint_next     = next_base[IDX_W-1:0];
                        ram_raddr     = ADDR_W'(next_base >> SHIFT);
                        dirty_next    = 1'b0;
                        from_ram_next = 1'b1;
                    end
                end
            end
            S_MODIFY:
            begin
                done_next       = 1'b1;
                first_page_next = '0;
                ram_waddr       = page_addr;
                ram_wdata       = ram_rdata;
                status_next     = ST_DONE;
                priority if (!page_ok)
                begin
                    status_next = ST_RANGE;
                end
                else if (action_reg == ACT_LOCK)
                begin
                    if (page_bit)
                    begin
                        status_next = ST_ALREADY;
                    end
                    else
                    begin
                        ram_we              = 1'b1;
                        ram_wdata[page_off] = 1'b1;
                        free_next           = cnt_dec(free_reg);
                        resv_next           = cnt_inc(resv_reg, COUNT_MAX);
                    end
                end
                else
                begin
                    if (!page_bit)
                    begin
                        status_next = ST_ALREADY;
                    end
                    else
                    begin
                        ram_we              = 1'b1;
                        ram_wdata[page_off] = 1'b0;
                        free_next           = cnt_inc(free_reg, lim_reg);
                        if (action_reg == ACT_FREE)
                        begin
                            used_next = cnt_dec(used_reg);
                        end
                        else
                        begin
                            resv_next = cnt_dec(resv_reg);
                        end
                        // freed page pulls the search start down
                        if (hint_reg > {1'b0, page_reg})
                        begin
                            hint_next = {1'b0, page_reg};
                        end
                    end
                end
            end
            default:
            begin
                clr_addr_next = '0;
            end
        endcase

        // page_count write: restart counters, clearing pass follows
        if (cfg_valid)
        begin
            lim_next      = cfg_lim;
            hint_next     = '0;
            used_next     = '0;
            resv_next     = '0;
            free_next     = cfg_lim;
            clr_addr_next = '0;
        end
    end

    // control and allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            lim_reg      <= LIM_RST;
            hint_reg     <= '0;
            free_reg     <= LIM_RST;
            used_reg     <= '0;
            resv_reg     <= '0;
            got_reg      <= 1'b0;
            dirty_reg    <= 1'b0;
            from_ram_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            lim_reg      <= lim_next;
            hint_reg     <= hint_next;
            free_reg     <= free_next;
            used_reg     <= used_next;
            resv_reg     <= resv_next;
            got_reg      <= got_next;
            dirty_reg    <= dirty_next;
            from_ram_reg <= from_ram_next;
            done_reg     <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        page_reg       <= page_next;
        remain_reg     <= remain_next;
        first_reg      <= first_next;
        word_reg       <= word_next;
        first_page_reg <= first_page_next;
        status_reg     <= status_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign first_page     = first_page_reg;
    assign status         = status_reg;
    assign free_pages     = free_reg;
    assign used_pages     = used_reg;
    assign reserved_pages = resv_reg;

    `BPFA_ASSERT_ALWAYS(a_hint_bound, clk, rst_n, hint_reg <= lim_reg, "search hint past page limit")
    `BPFA_ASSERT_ALWAYS(a_free_bound, clk, rst_n, free_reg <= lim_reg, "free count past page limit")
    `BPFA_ASSERT_IMPLY(a_done_src, clk, rst_n, done_reg, $past(state_reg == S_ALLOC || state_reg == S_MODIFY), "result strobe without a command at work")
    `BPFA_ASSERT_IMPLY(a_range_action, clk, rst_n, done_reg && status_reg == ST_RANGE, action_reg != ACT_ALLOC, "range error on allocate")

endmodule

[hw/rtl/bpfa_zero_scan.sv]
// first clear bit search over one bitmap word, at or above a bit offset
// depends on bpfa_pkg
module bpfa_zero_scan import bpfa_pkg::*;
#(
    parameter int SLICE_BITS = DEF_WORD_BITS
)
(
    input  logic [SLICE_BITS-1:0]         word,
    input  logic [$clog2(SLICE_BITS)-1:0] offset,
    output bpfa_hit_t                     hit
);

    localparam int POS_W = $clog2(SLICE_BITS);

    logic [SLICE_BITS-1:0] masked;
    logic [SLICE_BITS-1:0] inv;
    logic [SLICE_BITS-1:0] lowest;
    logic [SCAN_POS_W-1:0] pos_acc;

    // bits below the offset count as taken
    always_comb
    begin
        for (int i = 0; i < SLICE_BITS; i++)
        begin
            masked[i] = word[i] | (POS_W'(i) < offset);
        end
    end

    // isolate the lowest clear bit
    assign inv    = ~masked;
    assign lowest = inv & (~inv + 1'b1);

    always_comb
    begin
        pos_acc = '0;
        for (int i = 0; i < SLICE_BITS; i++)
        begin
            pos_acc = pos_acc | (lowest[i] ? SCAN_POS_W'(i) : '0);
        end
    end

    assign hit.found = |inv;
    assign hit.pos   = pos_acc;

endmodule

[hw/rtl/bpfa_map_ram.sv]
// bitmap word memory, one write port and one registered read port
// depends on bpfa_pkg
module bpfa_map_ram import bpfa_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_PAGES / DEF_WORD_BITS,
    parameter int DATA_W = DEF_WORD_BITS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for bitmap_page_frame_allocator_core
// depends on bpfa_pkg and the core; holds its own allocator predictor in a scoreboard class

module tb;
    import bpfa_pkg::*;

    // one expected result of the allocator
    typedef struct {
        logic [PAGE_W-1:0]  first_page;
        status_t            status;
        logic [COUNT_W-1:0] free_pages;
        logic [COUNT_W-1:0] used_pages;
        logic [COUNT_W-1:0] reserved_pages;
    } page_result_t;

    // predictor of the allocator plus the queue of results still owed by the core
    class page_alloc_scoreboard;
        bit [63:0]    page_map [1024];
        int unsigned  page_limit;
        int unsigned  hint;
        int unsigned  free_cnt;
        int unsigned  used_cnt;
        int unsigned  rsv_cnt;
        page_result_t owed_q[$];
        int unsigned  errors;

        function new();
            errors = 0;
            load_page_count(PAGE_COUNT_RST);
        endfunction

        // any page_count write starts over with an empty map
        function void load_page_count(bit [CFG_W-1:0] value);
            int unsigned v;
            v = 32'(value);
            page_limit = (v > DEF_MAX_PAGES) ? DEF_MAX_PAGES : v;
            foreach (page_map[i])
                page_map[i] = '0;
            hint     = 0;
            used_cnt = 0;
            rsv_cnt  = 0;
            free_cnt = page_limit;
        endfunction

        function int unsigned sat_up(int unsigned v, int unsigned top);
            return (v >= top) ? top : v + 1;
        endfunction

        function int unsigned sat_down(int unsigned v);
            return (v == 0) ? 0 : v - 1;
        endfunction

        // first-fit from the hint; a miss parks the hint at the page limit
        function bit grab_first_free(output int unsigned got);
            got = 0;
            while (hint < page_limit)
            begin
                if (!page_map[hint / 64][hint % 64])
                begin
                    page_map[hint / 64][hint % 64] = 1'b1;
                    free_cnt = sat_down(free_cnt);
                    rsv_cnt  = sat_up(rsv_cnt, 32'(COUNT_MAX));
                    used_cnt = sat_up(used_cnt, 32'(COUNT_MAX));
                    got = hint;
                    return 1'b1;
                end
                hint++;
            end
            hint = page_limit;
            return 1'b0;
        endfunction

        function void note_command(action_t act, bit [PAGE_W-1:0] pg, bit [BLOCK_W-1:0] bc);
            page_result_t r;
            int unsigned  n;
            int unsigned  got;
            int unsigned  p;
            r.first_page = '0;
            r.status     = ST_DONE;
            p = 32'(pg);
            if (act == ACT_ALLOC)
            begin
                n = (bc == 0) ? 1 : 32'(bc);
                if (n > 32'(MAX_BLOCKS))
                    n = 32'(MAX_BLOCKS);
                for (int i = 0; i < n; i++)
                begin
                    if (!grab_first_free(got))
                    begin
                        r.status = ST_NO_FREE;
                        break;
                    end
                    if (i == 0)
                        r.first_page = PAGE_W'(got);
                end
            end
            else if (p >= page_limit)
            begin
                r.status = ST_RANGE;
            end
            else if (act == ACT_LOCK)
            begin
                if (page_map[p / 64][p % 64])
                begin
                    r.status = ST_ALREADY;
                end
                else
                begin
                    page_map[p / 64][p % 64] = 1'b1;
                    free_cnt = sat_down(free_cnt);
                    rsv_cnt  = sat_up(rsv_cnt, 32'(COUNT_MAX));
                end
            end
            else
            begin
                // free lowers the used count, unreserve the reserved count
                if (!page_map[p / 64][p % 64])
                begin
                    r.status = ST_ALREADY;
                end
                else
                begin
                    page_map[p / 64][p % 64] = 1'b0;
                    free_cnt = sat_up(free_cnt, page_limit);
                    if (act == ACT_FREE)
                        used_cnt = sat_down(used_cnt);
                    else
                        rsv_cnt = sat_down(rsv_cnt);
                    if (hint > p)
                        hint = p;
                end
            end
            r.free_pages     = COUNT_W'(free_cnt);
            r.used_pages     = COUNT_W'(used_cnt);
            r.reserved_pages = COUNT_W'(rsv_cnt);
            owed_q.push_back(r);
        endfunction

        function void report_field(string name, logic [COUNT_W-1:0] want,
                                   logic [COUNT_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: %s mismatch, expected %0d got %0d", $realtime, name,
                             want, got);
            end
        endfunction

        function void check_result(logic [PAGE_W-1:0] fp, logic [1:0] st,
                                   logic [COUNT_W-1:0] fr, logic [COUNT_W-1:0] us,
                                   logic [COUNT_W-1:0] rs);
            page_result_t e;
            if (owed_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with no command outstanding", $realtime);
                return;
            end
            e = owed_q.pop_front();
            report_field("first_page", COUNT_W'(e.first_page), COUNT_W'(fp));
            report_field("status", COUNT_W'(e.status), COUNT_W'(st));
            report_field("free_pages", e.free_pages, fr);
            report_field("used_pages", e.used_pages, us);
            report_field("reserved_pages", e.reserved_pages, rs);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start;
    logic               busy;
    logic [1:0]         action;
    logic [PAGE_W-1:0]  page;
    logic [BLOCK_W-1:0] block_count;
    logic               done;
    logic [PAGE_W-1:0]  first_page;
    logic [1:0]         status;
    logic [COUNT_W-1:0] free_pages;
    logic [COUNT_W-1:0] used_pages;
    logic [COUNT_W-1:0] reserved_pages;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;

    page_alloc_scoreboard sb;
    int unsigned          idle_pct;   // chance in percent of a gap before a command
    int unsigned          cur_limit;  // effective page count, used to aim page numbers

    bitmap_page_frame_allocator_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .page           (page),
        .block_count    (block_count),
        .done           (done),
        .first_page     (first_page),
        .status         (status),
        .free_pages     (free_pages),
        .used_pages     (used_pages),
        .reserved_pages (reserved_pages),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // monitor: everything is sampled at the rising edge, before the edge's updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.load_page_count(cfg_data);
            if (start && !busy)
                sb.note_command(action_t'(action), page, block_count);
            if (done)
                sb.check_result(first_page, status, free_pages, used_pages, reserved_pages);
        end
    end

    // one command transfer; start stays high afterwards so back-to-back commands need no gap
    task automatic do_cmd(input action_t act, input int unsigned pg, input int unsigned bc);
        int unsigned gap;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(6, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        action      <= act;
        page        <= pg[PAGE_W-1:0];
        block_count <= bc[BLOCK_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // the edge that just accepted a command may not be noted yet, so wait for an edge before checking
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // page_count write while the core is idle; it triggers a clearing pass inside the core
    task automatic set_page_count(input int unsigned value);
        drain();
        repeat (16) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_limit = (value > DEF_MAX_PAGES) ? DEF_MAX_PAGES : value;
    endtask

    // random mix: pages mostly in the low window where allocations land, some near
    // and past the limit, some anywhere; block counts mostly small
    task automatic run_random(input int n);
        int unsigned r;
        int unsigned pg;
        int unsigned bc;
        int unsigned top;
        action_t     act;
        repeat (n)
        begin
            r = $urandom_range(99);
            act = (r < 35) ? ACT_ALLOC : (r < 60) ? ACT_FREE :
                  (r < 80) ? ACT_LOCK : ACT_UNRESERVE;
            r = $urandom_range(99);
            if (r < 70 && cur_limit > 0)
            begin
                top = (cur_limit > 300) ? 299 : cur_limit - 1;
                pg = $urandom_range(top, 0);
            end
            else if (r < 85)
            begin
                pg = (cur_limit >= 65536) ? 65535 - $urandom_range(2)
                                          : cur_limit + $urandom_range(2);
            end
            else
            begin
                pg = $urandom_range(65535);
            end
            r = $urandom_range(99);
            bc = (r < 60) ? $urandom_range(4) :
                 (r < 85) ? $urandom_range(64, 5) : $urandom_range(127, 65);
            do_cmd(act, pg, bc);
        end
    endtask

    initial
    begin
        sb          = new();
        idle_pct    = 0;
        cur_limit   = DEF_MAX_PAGES;
        start       <= 1'b0;
        action      <= ACT_ALLOC;
        page        <= '0;
        block_count <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset page count
        do_cmd(ACT_ALLOC, 0, 0);          // zero block count acts as one
        do_cmd(ACT_ALLOC, 0, 1);
        do_cmd(ACT_ALLOC, 0, 64);         // largest batch
        do_cmd(ACT_ALLOC, 0, 127);        // cut to the batch limit
        do_cmd(ACT_FREE, 0, 0);           // hint pulled back to page zero
        do_cmd(ACT_FREE, 0, 0);           // already clear
        do_cmd(ACT_ALLOC, 0, 1);          // refills the hole
        do_cmd(ACT_UNRESERVE, 1, 0);      // only the reserved count drops
        do_cmd(ACT_LOCK, 65535, 0);       // top page
        do_cmd(ACT_LOCK, 65535, 0);       // already locked
        do_cmd(ACT_UNRESERVE, 65535, 0);
        do_cmd(ACT_UNRESERVE, 65535, 0);  // already clear

        set_page_count(100);
        do_cmd(ACT_LOCK, 7, 0);
        do_cmd(ACT_FREE, 7, 0);           // used count held at zero
        do_cmd(ACT_LOCK, 100, 0);         // first page out of range
        do_cmd(ACT_FREE, 65535, 0);       // far out of range
        do_cmd(ACT_ALLOC, 0, 64);
        do_cmd(ACT_ALLOC, 0, 64);         // runs out partway, earlier pages kept
        do_cmd(ACT_ALLOC, 0, 1);          // fails at once

        set_page_count(0);                // no pages at all
        do_cmd(ACT_ALLOC, 0, 3);
        do_cmd(ACT_FREE, 0, 0);

        set_page_count(131071);           // above the maximum, acts as the maximum
        do_cmd(ACT_LOCK, 65535, 0);
        do_cmd(ACT_ALLOC, 0, 2);

        // random phases with different page counts and sender idling
        set_page_count(200);
        idle_pct = 0;
        run_random(110);
        set_page_count(64);
        idle_pct = 62;
        run_random(90);
        set_page_count(1);
        idle_pct = 10;
        run_random(40);
        set_page_count(1000);
        idle_pct = 62;
        run_random(90);
        set_page_count(65536);
        idle_pct = 0;
        run_random(80);
        set_page_count(70000);
        idle_pct = 10;
        run_random(60);

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog well beyond the slowest legal run, clearing passes included
    initial
    begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
